@@ rtl/core/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// Deque package
// Operation codes, result status codes, controller states and the fixed
// payload widths shared by the deque modules.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int KEY_W         = 16;
    localparam int VAL_W         = 16;
    localparam int WORD_W        = KEY_W + VAL_W;
    localparam int FUNC_W        = 3;
    localparam int STATUS_W      = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH_FRONT = 3'd0,
        FUNC_PUSH_BACK  = 3'd1,
        FUNC_POP_FRONT  = 3'd2,
        FUNC_POP_BACK   = 3'd3,
        FUNC_LIST       = 3'd4,
        FUNC_FIND       = 3'd5
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_EMPTY   = 2'd1,
        STATUS_FULL    = 2'd2,
        STATUS_MISSING = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_DATA,
        S_LIST_RD,
        S_LIST_DATA,
        S_FIND_RD,
        S_FIND_CHK
    } deq_state_t;

endpackage

@@ rtl/core/deque_with_key_search_core.sv @@
// ----------------------------------------------------------------------------
// Deque with key search
// Bounded double-ended queue of key and value entries held in a ring buffer,
// with pop from either end, listing from the front and search by key.
//
//   Channel  Valid      Stall      Payload
//   input    in_valid   in_stall   func, entry_key, entry_value
//   output   out_valid  out_stall  status, out_key, out_value, last_of_run
//
// A push, or a pop, listing or search on an empty store, loads its result
// directly; a pop loads the entry as it comes out of the synchronous store in
// the cycle after the read. A listing and a search read the stored entries
// from the front, each entry read and then handled before the next read is
// issued; a search stops at the first matching key. A listing waits before
// each read while the output channel is stalled. After reset the store is
// empty and no clearing pass is needed; entries are read only once written.
// ----------------------------------------------------------------------------
module deque_with_key_search_core
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [FUNC_W-1:0]   func,
    input  logic [KEY_W-1:0]    entry_key,
    input  logic [VAL_W-1:0]    entry_value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [KEY_W-1:0]    out_key,
    output logic [VAL_W-1:0]    out_value,
    output logic                last_of_run
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic              mem_wr_en;
    logic [IDX_W-1:0]  mem_wr_addr;
    logic [WORD_W-1:0] mem_wr_data;
    logic              mem_rd_en;
    logic [IDX_W-1:0]  mem_rd_addr;
    logic [WORD_W-1:0] mem_rd_data;

    deq_ctrl #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .entry_key   (entry_key),
        .entry_value (entry_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .out_key     (out_key),
        .out_value   (out_value),
        .last_of_run (last_of_run),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    deq_store #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

@@ rtl/core/deq_store.sv @@
// ----------------------------------------------------------------------------
// Deque entry store
// Single-port-write, single-port-read synchronous memory holding the ring of
// key and value words, with registered read data.
// ----------------------------------------------------------------------------
module deq_store
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/core/deq_ctrl.sv @@
// ----------------------------------------------------------------------------
// Deque controller
// Holds the front index and entry count, sequences pushes, pops, listings and
// key searches against the entry store, and drives the result register.
// ----------------------------------------------------------------------------
module deq_ctrl
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [FUNC_W-1:0]   func,
    input  logic [KEY_W-1:0]    entry_key,
    input  logic [VAL_W-1:0]    entry_value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [KEY_W-1:0]    out_key,
    output logic [VAL_W-1:0]    out_value,
    output logic                last_of_run,
    output logic                mem_wr_en,
    output logic [IDX_W-1:0]    mem_wr_addr,
    output logic [WORD_W-1:0]   mem_wr_data,
    output logic                mem_rd_en,
    output logic [IDX_W-1:0]    mem_rd_addr,
    input  logic [WORD_W-1:0]   mem_rd_data
);

    localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W + 1)'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    deq_state_t        state_reg, state_next;
    logic [IDX_W-1:0]  front_reg, front_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  offset_reg, offset_next;
    logic [KEY_W-1:0]  key_reg, key_next;

    logic              out_valid_reg, out_valid_next;
    status_t           status_reg;
    logic [KEY_W-1:0]  out_key_reg;
    logic [VAL_W-1:0]  out_value_reg;
    logic              last_reg;

    logic              ld_en;
    status_t           ld_status;
    logic [WORD_W-1:0] ld_word;
    logic              ld_last;

    logic              accept;
    logic              out_free;
    logic              is_empty;
    logic              is_full;
    logic [IDX_W-1:0]  last_off;
    logic              at_last;
    logic              key_match;
    logic [IDX_W-1:0]  front_dec;
    logic [IDX_W-1:0]  front_inc;

    function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                              input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_X)
        begin
            sum = sum - DEPTH_X;
        end
        return sum[IDX_W-1:0];
    endfunction

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == S_IDLE) && out_free);
    assign accept    = in_valid && !in_stall;
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == FULL_CNT);
    assign last_off  = IDX_W'(count_reg - CNT_W'(1));
    assign at_last   = (offset_reg == last_off);
    assign key_match = (mem_rd_data[WORD_W-1:VAL_W] == key_reg);
    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - IDX_W'(1);
    assign front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + IDX_W'(1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (func)
                        FUNC_POP_FRONT, FUNC_POP_BACK:
                        begin
                            if (!is_empty)
                            begin
                                state_next = S_POP_DATA;
                            end
                        end
                        FUNC_LIST:
                        begin
                            if (!is_empty)
                            begin
                                state_next = S_LIST_RD;
                            end
                        end
                        FUNC_FIND:
                        begin
                            if (!is_empty)
                            begin
                                state_next = S_FIND_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_POP_DATA:
            begin
                state_next = S_IDLE;
            end
            S_LIST_RD:
            begin
                if (out_free)
                begin
                    state_next = S_LIST_DATA;
                end
            end
            S_LIST_DATA:
            begin
                state_next = at_last ? S_IDLE : S_LIST_RD;
            end
            S_FIND_RD:
            begin
                state_next = S_FIND_CHK;
            end
            S_FIND_CHK:
            begin
                state_next = (key_match || at_last) ? S_IDLE : S_FIND_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        front_next  = front_reg;
        count_next  = count_reg;
        offset_next = offset_reg;
        key_next    = key_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = front_reg;
        mem_wr_data = {entry_key, entry_value};
        mem_rd_en   = 1'b0;
        mem_rd_addr = slot(front_reg, offset_reg);
        ld_en       = 1'b0;
        ld_status   = STATUS_OK;
        ld_word     = '0;
        ld_last     = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    key_next    = entry_key;
                    offset_next = '0;
                    unique case (func)
                        FUNC_PUSH_FRONT:
                        begin
                            ld_en = 1'b1;
                            if (is_full)
                            begin
                                ld_status = STATUS_FULL;
                            end
                            else
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = front_dec;
                                front_next  = front_dec;
                                count_next  = count_reg + CNT_W'(1);
                            end
                        end
                        FUNC_PUSH_BACK:
                        begin
                            ld_en = 1'b1;
                            if (is_full)
                            begin
                                ld_status = STATUS_FULL;
                            end
                            else
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = slot(front_reg, IDX_W'(count_reg));
                                count_next  = count_reg + CNT_W'(1);
                            end
                        end
                        FUNC_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                ld_en     = 1'b1;
                                ld_status = STATUS_EMPTY;
                            end
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = front_reg;
                                front_next  = front_inc;
                                count_next  = count_reg - CNT_W'(1);
                            end
                        end
                        FUNC_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                ld_en     = 1'b1;
                                ld_status = STATUS_EMPTY;
                            end
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = slot(front_reg, last_off);
                                count_next  = count_reg - CNT_W'(1);
                            end
                        end
                        FUNC_LIST:
                        begin
                            if (is_empty)
                            begin
                                ld_en     = 1'b1;
                                ld_status = STATUS_EMPTY;
                            end
                        end
                        FUNC_FIND:
                        begin
                            if (is_empty)
                            begin
                                ld_en     = 1'b1;
                                ld_status = STATUS_MISSING;
                            end
                        end
                        default:
                        begin
                            ld_en = 1'b0;
                        end
                    endcase
                end
            end
            S_POP_DATA:
            begin
                ld_en   = 1'b1;
                ld_word = mem_rd_data;
            end
            S_LIST_RD:
            begin
                mem_rd_en = out_free;
            end
            S_LIST_DATA:
            begin
                ld_en   = 1'b1;
                ld_word = mem_rd_data;
                ld_last = at_last;
                if (!at_last)
                begin
                    offset_next = offset_reg + IDX_W'(1);
                end
            end
            S_FIND_RD:
            begin
                mem_rd_en = 1'b1;
            end
            S_FIND_CHK:
            begin
                if (key_match)
                begin
                    ld_en   = 1'b1;
                    ld_word = mem_rd_data;
                end
                else if (at_last)
                begin
                    ld_en     = 1'b1;
                    ld_status = STATUS_MISSING;
                end
                else
                begin
                    offset_next = offset_reg + IDX_W'(1);
                end
            end
            default:
            begin
                ld_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (ld_en)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        offset_reg <= offset_next;
        key_reg    <= key_next;
        if (ld_en)
        begin
            status_reg    <= ld_status;
            out_key_reg   <= ld_word[WORD_W-1:VAL_W];
            out_value_reg <= ld_word[VAL_W-1:0];
            last_reg      <= ld_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign out_key     = out_key_reg;
    assign out_value   = out_value_reg;
    assign last_of_run = last_reg;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Deque with key search: self-checking testbench
// A short table of directed items covers the empty and full store, both
// unused operation codes, duplicated keys and a listing of the whole store.
// It is followed by random items whose push and pop mix drifts between
// filling and draining. Every result is checked against a behavioural copy
// of the deque that the testbench keeps, while both handshake sides pause at
// random and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;

    import deq_pkg::*;

    localparam int DEPTH           = DEPTH_DEFAULT;
    localparam int IDLE_PCT        = 19;
    localparam int RANDOM_ITEMS    = 400;
    localparam int PRESSURE_AT     = 150;
    localparam int HOLD_CYCLES     = 300;
    localparam int QUIET_FROM      = 200;
    localparam int QUIET_TO        = 280;
    localparam int TAIL_CYCLES     = 40;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int REPORT_LIMIT    = 10;
    localparam int DIRECTED_COUNT  = 23;

    localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0] st;
        logic [KEY_W-1:0]    key;
        logic [VAL_W-1:0]    value;
        logic                last;
    } result_t;

    typedef struct packed {
        logic [FUNC_W-1:0] op;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [4:0]        reps;
        logic              typed;
        status_t           st;
    } stim_row_t;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_stall;
    logic [FUNC_W-1:0]   func        = '0;
    logic [KEY_W-1:0]    entry_key   = '0;
    logic [VAL_W-1:0]    entry_value = '0;
    logic                out_valid;
    logic                out_stall   = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    out_key;
    logic [VAL_W-1:0]    out_value;
    logic                last_of_run;

    logic                row_typed   = 1'b0;
    status_t             row_status  = STATUS_OK;
    bit                  quiet_stretch = 1'b0;

    logic [KEY_W+VAL_W-1:0] slots [DEPTH];
    int                     front_idx = 0;
    int                     live_count = 0;
    result_t                awaited_results [$];

    int mismatches      = 0;
    int items_seen      = 0;
    int results_checked = 0;
    int full_rejects    = 0;
    int find_hits       = 0;
    int longest_listing = 0;
    int stalled_cycles  = 0;

    stim_row_t directed_rows [DIRECTED_COUNT] = '{
        '{FUNC_POP_FRONT,  16'h0000, 16'h0000, 5'd1,  1'b1, STATUS_EMPTY},
        '{FUNC_POP_BACK,   16'h0000, 16'h0000, 5'd1,  1'b1, STATUS_EMPTY},
        '{FUNC_LIST,       16'h0000, 16'h0000, 5'd1,  1'b1, STATUS_EMPTY},
        '{FUNC_FIND,       16'h0000, 16'h0000, 5'd1,  1'b1, STATUS_MISSING},
        '{FUNC_SPARE_6,    16'hFFFF, 16'hFFFF, 5'd1,  1'b0, STATUS_OK},
        '{FUNC_SPARE_7,    16'h0000, 16'h0000, 5'd1,  1'b0, STATUS_OK},
        '{FUNC_PUSH_BACK,  16'hFFFF, 16'h0000, 5'd1,  1'b1, STATUS_OK},
        '{FUNC_PUSH_FRONT, 16'h0000, 16'hFFFF, 5'd1,  1'b1, STATUS_OK},
        '{FUNC_FIND,       16'hFFFF, 16'h0000, 5'd1,  1'b0, STATUS_OK},
        '{FUNC_FIND,       16'h1234, 16'h0000, 5'd1,  1'b1, STATUS_MISSING},
        '{FUNC_LIST,       16'h0000, 16'h0000, 5'd1,  1'b0, STATUS_OK},
        '{FUNC_POP_BACK,   16'h0000, 16'h0000, 5'd1,  1'b0, STATUS_OK},
        '{FUNC_POP_FRONT,  16'h0000, 16'h0000, 5'd1,  1'b0, STATUS_OK},
        '{FUNC_PUSH_FRONT, 16'h00A5, 16'h0001, 5'd1,  1'b0, STATUS_OK},
        '{FUNC_PUSH_BACK,  16'h00A5, 16'h0002, 5'd1,  1'b0, STATUS_OK},
        '{FUNC_PUSH_BACK,  16'h8000, 16'h7FF0, 5'd14, 1'b0, STATUS_OK},
        '{FUNC_PUSH_FRONT, 16'h5555, 16'hAAAA, 5'd1,  1'b1, STATUS_FULL},
        '{FUNC_PUSH_BACK,  16'hAAAA, 16'h5555, 5'd1,  1'b1, STATUS_FULL},
        '{FUNC_FIND,       16'h00A5, 16'h0000, 5'd1,  1'b0, STATUS_OK},
        '{FUNC_LIST,       16'h0000, 16'h0000, 5'd1,  1'b0, STATUS_OK},
        '{FUNC_POP_BACK,   16'h0000, 16'h0000, 5'd1,  1'b0, STATUS_OK},
        '{FUNC_POP_FRONT,  16'h0000, 16'h0000, 5'd16, 1'b0, STATUS_OK},
        '{FUNC_LIST,       16'h0000, 16'h0000, 5'd1,  1'b1, STATUS_EMPTY}
    };

    deque_with_key_search_core #(
        .DEPTH       (DEPTH)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .entry_key   (entry_key),
        .entry_value (entry_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .out_key     (out_key),
        .out_value   (out_value),
        .last_of_run (last_of_run)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        if (mismatches < REPORT_LIMIT)
        begin
            $display("[%0t] %s", $realtime, what);
        end
        mismatches++;
    endtask

    task automatic add_result(input status_t st, input logic [KEY_W+VAL_W-1:0] word,
                              input logic last, input bit record);
        if (record)
        begin
            awaited_results.push_back('{st, word[KEY_W+VAL_W-1:VAL_W], word[VAL_W-1:0], last});
        end
    endtask

    task automatic advance_deque(input logic [FUNC_W-1:0] op, input logic [KEY_W-1:0] key,
                                 input logic [VAL_W-1:0] value, input bit record);
        int pos;
        bit hit;
        hit = 1'b0;
        case (op)
            FUNC_PUSH_FRONT, FUNC_PUSH_BACK:
            begin
                if (live_count >= DEPTH)
                begin
                    full_rejects++;
                    add_result(STATUS_FULL, '0, 1'b1, record);
                end
                else
                begin
                    if (op == FUNC_PUSH_FRONT)
                    begin
                        front_idx = (front_idx + DEPTH - 1) % DEPTH;
                        slots[front_idx] = {key, value};
                    end
                    else
                    begin
                        slots[(front_idx + live_count) % DEPTH] = {key, value};
                    end
                    live_count++;
                    add_result(STATUS_OK, '0, 1'b1, record);
                end
            end
            FUNC_POP_FRONT, FUNC_POP_BACK:
            begin
                if (live_count == 0)
                begin
                    add_result(STATUS_EMPTY, '0, 1'b1, record);
                end
                else
                begin
                    if (op == FUNC_POP_FRONT)
                    begin
                        pos = front_idx;
                        front_idx = (front_idx + 1) % DEPTH;
                    end
                    else
                    begin
                        pos = (front_idx + live_count - 1) % DEPTH;
                    end
                    live_count--;
                    add_result(STATUS_OK, slots[pos], 1'b1, record);
                end
            end
            FUNC_LIST:
            begin
                if (live_count == 0)
                begin
                    add_result(STATUS_EMPTY, '0, 1'b1, record);
                end
                for (int i = 0; i < live_count; i++)
                begin
                    add_result(STATUS_OK, slots[(front_idx + i) % DEPTH],
                               i == live_count - 1, record);
                end
                if (live_count > longest_listing)
                begin
                    longest_listing = live_count;
                end
            end
            FUNC_FIND:
            begin
                for (int i = 0; i < live_count && !hit; i++)
                begin
                    pos = (front_idx + i) % DEPTH;
                    if (slots[pos][KEY_W+VAL_W-1:VAL_W] == key)
                    begin
                        hit = 1'b1;
                        find_hits++;
                        add_result(STATUS_OK, slots[pos], 1'b1, record);
                    end
                end
                if (!hit)
                begin
                    add_result(STATUS_MISSING, '0, 1'b1, record);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && in_valid && !in_stall)
        begin
            items_seen++;
            if (row_typed)
            begin
                add_result(row_status, '0, 1'b1, 1'b1);
            end
            advance_deque(func, entry_key, entry_value, !row_typed);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            results_checked++;
            if (awaited_results.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected result: status %0d key %h value %h last %b",
                                        status, out_key, out_value, last_of_run));
            end
            else
            begin
                want = awaited_results.pop_front();
                if (status !== want.st || out_key !== want.key ||
                    out_value !== want.value || last_of_run !== want.last)
                begin
                    flag_mismatch($sformatf(
                        "expected status %0d key %h value %h last %b, got %0d %h %h %b",
                        want.st, want.key, want.value, want.last,
                        status, out_key, out_value, last_of_run));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            stalled_cycles = 0;
        end
        else
        begin
            stalled_cycles++;
            if (stalled_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                         stalled_cycles, awaited_results.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin : receiver
        int held;
        bit pressed;
        held = 0;
        pressed = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!pressed && items_seen >= PRESSURE_AT)
            begin
                held++;
                out_stall <= 1'b1;
                if (held == HOLD_CYCLES)
                begin
                    pressed = 1'b1;
                end
            end
            else if (quiet_stretch)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    task automatic drive_item(input logic [FUNC_W-1:0] op, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] value, input logic typed,
                              input status_t st);
        while (!quiet_stretch && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        func        <= op;
        entry_key   <= key;
        entry_value <= value;
        row_typed   <= typed;
        row_status  <= st;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        @(negedge clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key(input bit for_find);
        if (for_find && live_count > 0 && $urandom_range(99) < 60)
        begin
            return slots[(front_idx + $urandom_range(live_count - 1)) % DEPTH]
                        [KEY_W+VAL_W-1:VAL_W];
        end
        if ($urandom_range(1) == 1)
        begin
            return KEY_W'($urandom_range(7));
        end
        return KEY_W'($urandom);
    endfunction

    initial
    begin : stimulus
        int counted;
        int push_bias;
        int pick;
        logic [FUNC_W-1:0] op;
        counted = 0;
        push_bias = 50;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            for (int r = 0; r < directed_rows[i].reps; r++)
            begin
                drive_item(directed_rows[i].op,
                           KEY_W'(directed_rows[i].key + r),
                           VAL_W'(directed_rows[i].value + r),
                           directed_rows[i].typed,
                           directed_rows[i].st);
            end
        end

        while (counted < RANDOM_ITEMS)
        begin
            if (counted % 40 == 0)
            begin
                case ($urandom_range(2))
                    0: push_bias = 10;
                    1: push_bias = 50;
                    default: push_bias = 90;
                endcase
            end
            quiet_stretch = counted >= QUIET_FROM && counted < QUIET_TO;
            if ($urandom_range(99) < 3)
            begin
                op = $urandom_range(1) ? FUNC_SPARE_6 : FUNC_SPARE_7;
            end
            else
            begin
                counted++;
                pick = $urandom_range(99);
                if (pick < 8)
                begin
                    op = FUNC_LIST;
                end
                else if (pick < 25)
                begin
                    op = FUNC_FIND;
                end
                else if ($urandom_range(99) < push_bias)
                begin
                    op = $urandom_range(1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK;
                end
                else
                begin
                    op = $urandom_range(1) ? FUNC_POP_FRONT : FUNC_POP_BACK;
                end
            end
            drive_item(op, pick_key(op == FUNC_FIND), VAL_W'($urandom), 1'b0, STATUS_OK);
        end
        quiet_stretch = 1'b0;
        in_valid <= 1'b0;

        while (awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (awaited_results.size() != 0)
        begin
            flag_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
        end

        $display("Checked %0d results from %0d items, longest listing %0d entries.",
                 results_checked, items_seen, longest_listing);
        $display("Pushes refused on a full store: %0d; searches that found their key: %0d.",
                 full_rejects, find_hits);
        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
